>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the subframe packer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/iec_sfp_pkg.sv
// ----------------------------------------------------------------------------
// iec_sfp_pkg
// Constants, register indexes and shared types of the subframe packer.
// ----------------------------------------------------------------------------
package iec_sfp_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int WORD_W      = 32;
    localparam int CHCNT_W     = 4;
    localparam int STATUS_W    = 42;
    localparam int FRAME_W     = 8;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STATUS_W;
    localparam int STAT_IDX_W  = 6;

    // Block structure
    localparam logic [FRAME_W-1:0] BLOCK_LAST    = 8'd191;
    localparam logic [FRAME_W-1:0] STATUS_FRAMES = 8'd42;
    localparam logic [CHCNT_W-1:0] MIN_CHANNELS  = 4'd2;
    localparam logic [CHCNT_W-1:0] MAX_CHANNELS  = 4'd8;

    // Channel number field inside the status word
    localparam int CHAN_FIELD_LSB = 20;
    localparam int CHAN_FIELD_MSB = 23;

    // Subframe word bit positions
    localparam int B_BIT      = 28;
    localparam int P_BIT      = 27;
    localparam int C_BIT      = 26;
    localparam int SAMPLE_LSB = 8;
    localparam int SAMPLE_MSB = SAMPLE_LSB + SAMPLE_W - 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STATUS_WORD   = 2'd1;

    // Settings seen by the sequencer
    typedef struct packed {
        logic [CHCNT_W-1:0]  channels;   // clamped to 2..8
        logic [STATUS_W-1:0] status;
    } cfg_t;

    // Per-subframe flags from the sequencer
    typedef struct packed {
        logic block_start;
        logic status_bit;
    } frame_info_t;

endpackage

>>> sv/iec_sfp_cfg.sv
// ----------------------------------------------------------------------------
// iec_sfp_cfg
// Configuration registers; presents the clamped channel count and status word.
// ----------------------------------------------------------------------------
module iec_sfp_cfg import iec_sfp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CHCNT_W-1:0]  chcnt_reg;
    logic [CHCNT_W-1:0]  chcnt_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    // Decode a register write
    always_comb begin
        chcnt_next  = chcnt_reg;
        status_next = status_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_CHANNEL_COUNT: chcnt_next  = cfg_data[CHCNT_W-1:0];
                CFG_IDX_STATUS_WORD:   status_next = cfg_data[STATUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chcnt_reg  <= MIN_CHANNELS;
            status_reg <= '0;
        end else begin
            chcnt_reg  <= chcnt_next;
            status_reg <= status_next;
        end
    end

    // Clamp the channel count into its legal range
    always_comb begin
        cfg.status = status_reg;
        if (chcnt_reg < MIN_CHANNELS) begin
            cfg.channels = MIN_CHANNELS;
        end else if (chcnt_reg > MAX_CHANNELS) begin
            cfg.channels = MAX_CHANNELS;
        end else begin
            cfg.channels = chcnt_reg;
        end
    end

endmodule

>>> sv/iec_sfp_seq.sv
// ----------------------------------------------------------------------------
// iec_sfp_seq
// Frame and channel counters; selects the block-start and status bits.
// ----------------------------------------------------------------------------
module iec_sfp_seq import iec_sfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        restart,
    input  cfg_t        cfg,
    output frame_info_t info
);

    logic [FRAME_W-1:0]  frame_reg;
    logic [FRAME_W-1:0]  frame_next;
    logic [CHAN_W-1:0]   chan_reg;
    logic [CHAN_W-1:0]   chan_next;
    logic [FRAME_W-1:0]  frame_cur;
    logic [CHAN_W-1:0]   chan_cur;
    logic [CHCNT_W-1:0]  chan_num;
    logic [STATUS_W-1:0] status_ch;

    // Restart clears both counters ahead of this subframe
    assign frame_cur = restart ? '0 : frame_reg;
    assign chan_cur  = restart ? '0 : chan_reg;
    assign chan_num  = {1'b0, chan_cur} + CHCNT_W'(1);

    // Insert the channel number and pick this frame's status bit
    always_comb begin
        status_ch = cfg.status;
        status_ch[CHAN_FIELD_MSB:CHAN_FIELD_LSB] = chan_num;
        info.block_start = (frame_cur == '0);
        if (frame_cur < STATUS_FRAMES) begin
            info.status_bit = status_ch[frame_cur[STAT_IDX_W-1:0]];
        end else begin
            info.status_bit = 1'b0;
        end
    end

    // Advance channel, and frame at the last channel
    always_comb begin
        frame_next = frame_reg;
        chan_next  = chan_reg;
        if (advance) begin
            if (chan_num >= cfg.channels) begin
                chan_next  = '0;
                frame_next = (frame_cur == BLOCK_LAST) ? '0 : frame_cur + FRAME_W'(1);
            end else begin
                chan_next  = chan_num[CHAN_W-1:0];
                frame_next = frame_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            chan_reg  <= '0;
        end else begin
            frame_reg <= frame_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

>>> sv/iec_sfp_pack.sv
// ----------------------------------------------------------------------------
// iec_sfp_pack
// Assembles the subframe word: sample, status, even parity and block start.
// ----------------------------------------------------------------------------
module iec_sfp_pack import iec_sfp_pkg::*; (
    input  logic [SAMPLE_W-1:0] sample,
    input  frame_info_t         info,
    output logic [WORD_W-1:0]   word
);

    // Unused bits stay zero
    always_comb begin
        word = '0;
        word[SAMPLE_MSB:SAMPLE_LSB] = sample;
        word[C_BIT] = info.status_bit;
        word[P_BIT] = (^sample) ^ info.status_bit;
        word[B_BIT] = info.block_start;
    end

endmodule

>>> sv/iec60958_subframe_packer.sv
// ----------------------------------------------------------------------------
// iec60958_subframe_packer
// Packs interleaved 16-bit PCM samples into 32-bit IEC 60958 subframe words.
//
// One sample in, one subframe word out, one transaction per clock when both
// sides are ready. An accepted sample is held in an input register, and the
// word is formed by short logic into the output register when that register
// is free or draining; m_valid then rises and the word can leave. The output
// register decouples the two sides: a new sample is taken while a finished
// word still waits. Frame (0..191) and channel counters advance as each word
// is formed; setting s_start_of_transfer restarts both before that sample.
// Configuration (index 0: channel count, clamped to 2..8; index 1: 42
// channel-status bits) is always accepted and should only be written while
// the block is idle.
// ----------------------------------------------------------------------------
module iec60958_subframe_packer import iec_sfp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Sample input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_start_of_transfer,
    // Subframe output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_subframe_word,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                sot_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic                advance;
    logic                s_take;
    cfg_t                cfg;
    frame_info_t         info;

    assign cfg_ready = 1'b1;

    iec_sfp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held sample on when the output register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    iec_sfp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .restart (sot_reg),
        .cfg     (cfg),
        .info    (info)
    );

    iec_sfp_pack u_pack (
        .sample (sample_reg),
        .info   (info),
        .word   (word_next)
    );

    // Hold valid until the next stage takes the transaction
    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            sample_reg <= s_sample;
            sot_reg    <= s_start_of_transfer;
        end
        if (advance) begin
            word_reg <= word_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_subframe_word = word_reg;

endmodule

>>> sv/iec_sfp_chk.sv
// ----------------------------------------------------------------------------
// iec_sfp_chk
// Port-level checks on the subframe output of the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iec_sfp_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_subframe_word
);

    // No transaction offered straight out of reset
    `ASSERT_CLK(a_idle_after_reset, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

    // A stalled transaction stays offered
    `ASSERT_CLK_RST(a_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped")

    // A stalled word holds its value
    `ASSERT_CLK_RST(a_word_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_subframe_word), "word changed while stalled")

    // Parity covers sample and status bit with even sense
    `ASSERT_CLK_RST(a_even_parity, aclk, aresetn, m_valid |-> ((^m_subframe_word[27:26]) ^ (^m_subframe_word[23:8])) == 1'b0, "odd parity in subframe")

    // Bits outside the defined fields are zero
    `ASSERT_CLK_RST(a_spare_zero, aclk, aresetn, m_valid |-> (m_subframe_word[31:29] == 3'd0) && (m_subframe_word[25:24] == 2'd0) && (m_subframe_word[7:0] == 8'd0), "spare bits set")

endmodule

bind iec60958_subframe_packer iec_sfp_chk u_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_subframe_word (m_subframe_word)
);
